/* rtl/swa_pkg.sv */
// ============================================================================
// swa_pkg
// Shared types and constants for the spike-rejecting window average filter.
// ============================================================================
package swa_pkg;

    localparam int DATA_W    = 16;
    localparam int SPIKE_W   = 8;
    localparam int CH_W      = 2;
    localparam int ENABLE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SPIKE_W-1:0] SPIKE_MAX  = '1;
    localparam logic [DATA_W-1:0]  READ_FAIL  = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_ENABLE   = 2'd2;

    // Configuration reset values
    localparam logic [DATA_W-1:0]   RANGE_RST  = 16'd100;
    localparam logic [SPIKE_W-1:0]  LIMIT_RST  = 8'd3;
    localparam logic [ENABLE_W-1:0] ENABLE_RST = 2'b11;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_READ   = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

endpackage

/* rtl/spike_rejecting_window_average.sv */
// Sequence: a sample that enters the window passes through decide, RAM read, the
// 16-step divider and output load; any other item goes from decide to output load.
// A new item is taken only in idle, once the last result is in the output register.
// Reset: async active low; clears fill counts, spike counts, sums, averages and
// config (range 100, limit 3, enable 3). The sample RAM is not cleared.
// ============================================================================
// spike_rejecting_window_average
// Per-channel moving average with spike rejection. Samples live in a RAM as a
// circular buffer per channel; a running sum mod 2^16 is divided by the fill
// count in a shared serial divider.
// ============================================================================
module spike_rejecting_window_average
    import swa_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int WINDOW   = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CH_W-1:0]      channel,
    input  logic [DATA_W-1:0]    sample_mv,
    input  logic                 read_ok,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    average,
    output logic                 accepted,
    output logic [SPIKE_W-1:0]   spike_run
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int PW    = $clog2(WINDOW);
    localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t state_reg, state_next;

    // Configuration
    logic [DATA_W-1:0]   range_reg;
    logic [SPIKE_W-1:0]  limit_reg;
    logic [ENABLE_W-1:0] enable_reg;

    // Per-channel state
    logic [FW-1:0]      fill_reg   [CHANNELS];
    logic [PW-1:0]      wp_reg     [CHANNELS];
    logic [SPIKE_W-1:0] spike_reg  [CHANNELS];
    logic [DATA_W-1:0]  avg_reg    [CHANNELS];
    logic [DATA_W-1:0]  sum_reg    [CHANNELS];
    logic [DATA_W-1:0]  newest_reg [CHANNELS];

    // Captured transaction
    logic [CH_W-1:0]   ch_reg;
    logic [DATA_W-1:0] smp_reg;
    logic              ok_reg;
    logic              full_reg;

    // Pending result and output register
    logic [DATA_W-1:0]  res_avg_reg;
    logic               res_acc_reg;
    logic [SPIKE_W-1:0] res_run_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_avg_reg;
    logic               out_acc_reg;
    logic [SPIKE_W-1:0] out_run_reg;

    // Decision signals
    logic [CI_W-1:0]    ci;
    logic               bad_ch;
    logic               ch_en;
    logic               full;
    logic [DATA_W:0]    hi_bound;
    logic [DATA_W:0]    smp_plus;
    logic               in_rng;
    logic [SPIKE_W-1:0] spike_inc;
    logic               acc;
    logic [SPIKE_W-1:0] spike_new;

    // Update signals
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [DATA_W-1:0] sum_new;
    logic [FW-1:0]     fill_new;
    logic [PW-1:0]     wp_new;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    logic in_fire;
    logic out_fire;
    logic out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign average   = out_avg_reg;
    assign accepted  = out_acc_reg;
    assign spike_run = out_run_reg;

    // Spike decision for the captured sample
    always_comb
    begin
        ci        = ch_reg[CI_W-1:0];
        bad_ch    = ({1'b0, ch_reg} >= (CH_W + 1)'(CHANNELS));
        ch_en     = ch_reg[1] ? 1'b1 : enable_reg[ch_reg[0]];
        full      = (fill_reg[ci] == FW'(WINDOW));
        hi_bound  = {1'b0, newest_reg[ci]} + {1'b0, range_reg};
        smp_plus  = {1'b0, smp_reg} + {1'b0, range_reg};
        in_rng    = !full || (({1'b0, smp_reg} <= hi_bound)
                              && (smp_plus >= {1'b0, newest_reg[ci]}));
        spike_inc = (spike_reg[ci] == SPIKE_MAX) ? SPIKE_MAX : spike_reg[ci] + 1'b1;
        acc       = in_rng || (spike_inc >= limit_reg);
        spike_new = acc ? '0 : spike_inc;
    end

    // Window update: slot at write pointer is the oldest once full
    always_comb
    begin
        ram_addr  = AW'(AW'(ci) * AW'(WINDOW)) + AW'(wp_reg[ci]);
        sum_new   = sum_reg[ci] + smp_reg - (full_reg ? ram_rdata : '0);
        fill_new  = full_reg ? fill_reg[ci] : fill_reg[ci] + 1'b1;
        wp_new    = (wp_reg[ci] == PW'(WINDOW - 1)) ? '0 : wp_reg[ci] + 1'b1;
        ram_we    = (state_reg == S_READ);
        div_start = (state_reg == S_READ);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!bad_ch && ch_en && ok_reg && acc)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= RANGE_RST;
            limit_reg  <= LIMIT_RST;
            enable_reg <= ENABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPIKE_RANGE: range_reg  <= cfg_data;
                CFG_SPIKE_LIMIT: limit_reg  <= cfg_data[SPIKE_W-1:0];
                CFG_CH_ENABLE:   enable_reg <= cfg_data[ENABLE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Per-channel filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i]  <= '0;
                wp_reg[i]    <= '0;
                spike_reg[i] <= '0;
                avg_reg[i]   <= '0;
                sum_reg[i]   <= '0;
            end
        end
        else
        begin
            if ((state_reg == S_DECIDE) && !bad_ch && ch_en && ok_reg)
            begin
                spike_reg[ci] <= spike_new;
            end
            if (state_reg == S_READ)
            begin
                sum_reg[ci]  <= sum_new;
                fill_reg[ci] <= fill_new;
                wp_reg[ci]   <= wp_new;
            end
            if ((state_reg == S_DIV) && div_done)
            begin
                avg_reg[ci] <= div_q;
            end
        end
    end

    // Newest sample per channel, read only once the window is full
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            newest_reg[ci] <= smp_reg;
        end
    end

    // Captured transaction and pending result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg  <= channel;
            smp_reg <= sample_mv;
            ok_reg  <= read_ok;
        end
        if (state_reg == S_DECIDE)
        begin
            full_reg <= full;
            if (bad_ch)
            begin
                res_avg_reg <= '0;
                res_acc_reg <= 1'b0;
                res_run_reg <= '0;
            end
            else if (!ch_en)
            begin
                res_avg_reg <= avg_reg[ci];
                res_acc_reg <= 1'b0;
                res_run_reg <= spike_reg[ci];
            end
            else if (!ok_reg)
            begin
                res_avg_reg <= READ_FAIL;
                res_acc_reg <= 1'b0;
                res_run_reg <= spike_reg[ci];
            end
            else
            begin
                res_avg_reg <= avg_reg[ci];
                res_acc_reg <= acc;
                res_run_reg <= spike_new;
            end
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            res_avg_reg <= div_q;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_avg_reg <= res_avg_reg;
            out_acc_reg <= res_acc_reg;
            out_run_reg <= res_run_reg;
        end
    end

    // Sample storage
    swa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (smp_reg),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Average = sum / fill count
    swa_div #(
        .DW (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (fill_new),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

/* rtl/swa_ram.sv */
// ============================================================================
// swa_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/swa_div.sv */
// ============================================================================
// swa_div
// Restoring divider: 16-bit dividend by a small divisor, one bit per cycle.
// ============================================================================
module swa_div
    import swa_pkg::*;
#(
    parameter int DW = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DW-1:0]     divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DW:0]       rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]     dvs_reg, dvs_next;
    logic [DW:0]       trial;
    logic              qbit;
    logic [DW:0]       rem_step;

    // One trial subtraction per cycle
    always_comb
    begin
        trial    = {rem_reg[DW-1:0], quo_reg[DATA_W-1]};
        qbit     = (trial >= {1'b0, dvs_reg});
        rem_step = qbit ? (trial - {1'b0, dvs_reg}) : trial;
    end

    assign done     = busy_reg && (step_reg == STEP_W'(DIV_STEPS - 1));
    assign quotient = {quo_reg[DATA_W-2:0], qbit};

    // Next-state logic
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            quo_next  = {quo_reg[DATA_W-2:0], qbit};
            step_next = step_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule
